// ===== rtl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	typedef struct packed {
		logic load;
		logic step;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic lead_zero;
		logic last_digit;
		logic negative;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/sbda_dpath.sv =====
// ----------------------------------------------------------------------------
// sbda_dpath
// Magnitude and BCD registers, shift-and-add-3 step, digit counter and
// output character register.
// ----------------------------------------------------------------------------
module sbda_dpath #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] value,
	input  sbda_pkg::cmd_t         cmd,
	output sbda_pkg::stat_t        stat,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [5:0]             character,
	output logic                   is_last
);

	localparam int NDIG = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
	localparam int BW   = 4 * NDIG;
	localparam int BCW  = $clog2(VALUE_WIDTH + 1);
	localparam int DCW  = $clog2(NDIG + 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          bcd_adj;
	logic                   neg_q;
	logic [BCW-1:0]         bit_cnt_q;
	logic [DCW-1:0]         dig_cnt_q;
	logic [5:0]             char_q;
	logic                   last_q;
	logic                   valid_q;
	logic [3:0]             top_dig;

	assign top_dig = bcd_q[BW-1 -: 4];

	always_comb begin
		logic [3:0] d;
		bcd_adj = bcd_q;
		for (int i = 0; i < NDIG; i++) begin
			d = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
			neg_q <= value[VALUE_WIDTH-1];
			bcd_q <= '0;
		end else if (cmd.step) begin
			bcd_q <= {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BW-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= BCW'(VALUE_WIDTH);
			dig_cnt_q <= DCW'(NDIG);
		end else begin
			if (cmd.step)
				bit_cnt_q <= bit_cnt_q - 1'b1;
			if (cmd.skip || cmd.emit_digit)
				dig_cnt_q <= dig_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= sbda_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= sbda_pkg::CHAR_ZERO + {2'b00, top_dig};
			last_q <= stat.last_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.emit_sign || cmd.emit_digit)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	assign stat.conv_done  = (bit_cnt_q == '0);
	assign stat.lead_zero  = (top_dig == 4'd0);
	assign stat.last_digit = (dig_cnt_q == DCW'(1));
	assign stat.negative   = neg_q;
	assign stat.out_free   = !valid_q || out_ready;

	assign out_valid = valid_q;
	assign character = char_q;
	assign is_last   = last_q;

endmodule

// ===== rtl/sbda_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbda_ctrl
// Sequencer: load, convert, drop leading zeros, emit sign and digits.
// ----------------------------------------------------------------------------
module sbda_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sbda_pkg::stat_t stat,
	output sbda_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_SKIP  = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (stat.conv_done)
					state_d = ST_SKIP;
				else
					cmd.step = 1'b1;
			end
			ST_SKIP: begin
				if (stat.lead_zero && !stat.last_digit)
					cmd.skip = 1'b1;
				else
					state_d = stat.negative ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (stat.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (stat.out_free) begin
					cmd.emit_digit = 1'b1;
					if (stat.last_digit)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed two's complement value to its decimal ASCII text.
// ----------------------------------------------------------------------------
// One value is taken per transfer on the input channel and emitted as one
// character per output transfer, most significant digit first, with a leading
// minus sign for negative values and is_last on the final digit. A value is
// loaded, converted by VALUE_WIDTH shift-and-add-3 steps of the BCD datapath,
// then its suppressed leading zeros are dropped and its characters are emitted,
// each one waiting while the output is stalled. Suppressed zeros and digits
// always add up to the full digit count. The next value is taken while the
// last character still waits in the output register.
module signed_binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [5:0]             character,
	output logic                   is_last
);

	sbda_pkg::cmd_t  cmd;
	sbda_pkg::stat_t stat;

	sbda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sbda_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.character (character),
		.is_last   (is_last)
	);

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a load");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && character == sbda_pkg::CHAR_MINUS) |-> !is_last)
		else $error("minus sign marked as last character");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == sbda_pkg::CHAR_MINUS ||
			(character >= sbda_pkg::CHAR_ZERO && character <= 6'd57)))
		else $error("illegal output character");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.skip, cmd.emit_sign, cmd.emit_digit}))
		else $error("conflicting datapath commands");

endmodule

// ===== sim/tb_signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// tb_signed_binary_to_decimal_ascii
// Self-checking bench for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Signed 32-bit values go in through a queue-fed driver, and each accepted
// value is spelled out in the bench as the characters it must produce. A
// clocked monitor compares every output transfer with the oldest expected
// character. Stimulus starts with edge values (zero, one digit, powers of
// ten, the largest and most negative values), then mixes full-range and
// short values. Both sides idle at random, there is a calm stretch with no
// idling, a long output hold-off that backs up the input, and pauses where
// the sender waits until all text has drained.
// ----------------------------------------------------------------------------
module tb_signed_binary_to_decimal_ascii;

	localparam int VALUE_WIDTH = 32;
	localparam int IDLE_PCT    = 19;

	typedef struct packed {
		logic [5:0] code;
		logic       last;
	} glyph_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [VALUE_WIDTH-1:0] value     = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [5:0]             character;
	logic                   is_last;

	logic [VALUE_WIDTH-1:0] values_to_send[$];
	glyph_t                 pending_text[$];
	bit                     steady     = 1'b0;
	int                     mismatches = 0;
	int                     chars_seen = 0;

	signed_binary_to_decimal_ascii #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.is_last(is_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void spell_decimal(input logic [VALUE_WIDTH-1:0] v);
		logic             negative;
		logic [VALUE_WIDTH:0] mag;
		logic [3:0]       digits[0:19];
		int               ndig;
		glyph_t           g;
		negative = v[VALUE_WIDTH-1];
		mag = negative ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
		ndig = 0;
		do begin
			digits[ndig] = 4'(mag % 10);
			ndig++;
			mag = mag / 10;
		end while (mag != 0);
		if (negative) begin
			g.code = sbda_pkg::CHAR_MINUS;
			g.last = 1'b0;
			pending_text.push_back(g);
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			g.code = sbda_pkg::CHAR_ZERO + 6'(digits[i]);
			g.last = (i == 0);
			pending_text.push_back(g);
		end
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] random_value();
		logic [VALUE_WIDTH-1:0] v;
		int                     p;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(31);
			2: begin
				v = 1;
				p = $urandom_range(9);
				repeat (p) v = v * 10;
				v = v + $urandom_range(2) - 1;
			end
			default: v = $urandom_range(999);
		endcase
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	// driver: hold the offered value until its transfer, then pick the next
	always @(posedge clk or negedge arst_n) begin : drive_values
		logic                   nv;
		logic [VALUE_WIDTH-1:0] nval;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value    <= '0;
		end else begin
			nv   = in_valid;
			nval = value;
			if (in_valid && in_ready) begin
				spell_decimal(values_to_send.pop_front());
				nv = 1'b0;
			end
			if (!nv && values_to_send.size() != 0 &&
			    (steady || $urandom_range(99) >= IDLE_PCT)) begin
				nv   = 1'b1;
				nval = values_to_send[0];
			end
			in_valid <= nv;
			value    <= nval;
		end
	end

	// monitor: check each character, drop ready at random and once for long
	always @(posedge clk or negedge arst_n) begin : check_text
		int     hold_left;
		bit     hold_done;
		logic   rdy;
		glyph_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				chars_seen++;
				if (pending_text.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected character %0d is_last %0b",
					         $time, character, is_last);
				end else begin
					want = pending_text.pop_front();
					if (character !== want.code) begin
						mismatches++;
						$display("%0t: character expected %0d actual %0d",
						         $time, want.code, character);
					end
					if (is_last !== want.last) begin
						mismatches++;
						$display("%0t: is_last expected %0b actual %0b",
						         $time, want.last, is_last);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (!hold_done && chars_seen >= 600) begin
				hold_left = 500;
				hold_done = 1'b1;
				rdy = 1'b0;
			end else begin
				rdy = steady || $urandom_range(99) >= IDLE_PCT;
			end
			out_ready <= rdy;
		end
	end

	task automatic drain();
		while (values_to_send.size() != 0 || pending_text.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random(input int n);
		repeat (n) values_to_send.push_back(random_value());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		values_to_send.push_back(32'd0);
		values_to_send.push_back(32'd1);
		values_to_send.push_back(-32'sd1);
		values_to_send.push_back(32'd9);
		values_to_send.push_back(32'd10);
		values_to_send.push_back(-32'sd10);
		values_to_send.push_back(32'd99);
		values_to_send.push_back(32'd100);
		values_to_send.push_back(32'h7FFF_FFFF);
		values_to_send.push_back(32'h8000_0000);
		values_to_send.push_back(32'h8000_0001);
		values_to_send.push_back(32'd1_000_000_000);
		values_to_send.push_back(32'd999_999_999);
		values_to_send.push_back(-32'sd999_999_999);
		values_to_send.push_back(32'd1_234_567_890);
		values_to_send.push_back(-32'sd1_234_567_890);
		values_to_send.push_back(32'h5555_5555);
		values_to_send.push_back(32'hAAAA_AAAA);
		values_to_send.push_back(32'd65535);
		values_to_send.push_back(32'd65536);
		values_to_send.push_back(-32'sd65536);
		values_to_send.push_back(-32'sd5);
		values_to_send.push_back(32'd10000);
		drain();

		// sender pauses between phases until all text is out
		queue_random(150);
		drain();
		repeat (50) @(posedge clk);

		@(negedge clk);
		steady = 1'b1;
		queue_random(100);
		drain();
		@(negedge clk);
		steady = 1'b0;

		queue_random(150);
		drain();
		repeat (100) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sbda_pkg.sv
rtl/sbda_dpath.sv
rtl/sbda_ctrl.sv
rtl/signed_binary_to_decimal_ascii.sv
sim/tb_signed_binary_to_decimal_ascii.sv
